@@ hdl/spd_pkg.sv @@
// shared types and constants of the stroke point decimator
`default_nettype none

package spd_pkg;

  // field widths fixed by the item layout
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned NEAR_W   = 8;
  localparam int unsigned COUNT_W  = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd2;

  // result actions
  localparam logic [ACTION_W-1:0] ACT_DROP    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REPLACE = 2'd2;

  // near limit after reset
  localparam logic [NEAR_W-1:0] NEAR_RESET = 8'd2;

  // saturation value of the stored point count
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // stroke update decided for one item
  typedef struct packed {
    logic clear;
    logic append;
    logic replace;
  } spd_upd_t;

endpackage

`default_nettype wire

@@ hdl/spd_if.sv @@
// handshake channels of the stroke point decimator: items, results, configuration
`default_nettype none

interface spd_item_if #(
  parameter int unsigned CoordBits = 16
);
  import spd_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [KIND_W-1:0]           kind;
  logic signed [CoordBits-1:0] pos_x;
  logic signed [CoordBits-1:0] pos_y;

  modport source (output valid, output kind, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input kind, input pos_x, input pos_y, output ready);
endinterface

interface spd_result_if #(
  parameter int unsigned CoordBits = 16
);
  import spd_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [ACTION_W-1:0]         action;
  logic signed [CoordBits-1:0] out_x;
  logic signed [CoordBits-1:0] out_y;
  logic [COUNT_W-1:0]          slot_index;

  modport source (output valid, output action, output out_x, output out_y,
                  output slot_index, input ready);
  modport sink   (input valid, input action, input out_x, input out_y,
                  input slot_index, output ready);
endinterface

interface spd_cfg_if;
  import spd_pkg::*;

  logic              valid;
  logic              ready;
  logic [NEAR_W-1:0] near_limit;

  modport source (output valid, output near_limit, input ready);
  modport sink   (input valid, input near_limit, output ready);
endinterface

`default_nettype wire

@@ hdl/spd_cfg.sv @@
// near limit configuration register
`default_nettype none

module spd_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  spd_cfg_if.sink                        cfg_i,
  output logic [spd_pkg::NEAR_W-1:0]     near_limit_o
);
  import spd_pkg::*;

  logic [NEAR_W-1:0] near_q;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // register write on each beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NEAR_RESET;
    end else if (cfg_i.valid) begin
      near_q <= cfg_i.near_limit;
    end
  end

  assign near_limit_o = near_q;

endmodule

`default_nettype wire

@@ hdl/spd_eval.sv @@
// decision logic: drop, append or replace one point against the stroke state
`default_nettype none

module spd_eval #(
  parameter int unsigned CoordBits = 16
) (
  input  wire logic [spd_pkg::KIND_W-1:0]    kind_i,
  input  wire logic signed [CoordBits-1:0]   pos_x_i,
  input  wire logic signed [CoordBits-1:0]   pos_y_i,
  input  wire logic signed [CoordBits-1:0]   last_x_i,
  input  wire logic signed [CoordBits-1:0]   last_y_i,
  input  wire logic signed [CoordBits-1:0]   prev_x_i,
  input  wire logic signed [CoordBits-1:0]   prev_y_i,
  input  wire logic [spd_pkg::COUNT_W-1:0]   count_i,
  input  wire logic [spd_pkg::NEAR_W-1:0]    near_limit_i,
  output spd_pkg::spd_upd_t                  upd_o,
  output logic [spd_pkg::ACTION_W-1:0]       action_o
);
  import spd_pkg::*;

  // differences need one bit more than a coordinate
  localparam int unsigned DiffBits = CoordBits + 1;
  localparam int unsigned ProdBits = 2 * DiffBits;

  logic signed [DiffBits-1:0] near_dx, near_dy;
  logic [DiffBits-1:0]        near_ax, near_ay;
  logic signed [DiffBits-1:0] seg_dx, seg_dy;   // last minus point before last
  logic signed [DiffBits-1:0] far_dx, far_dy;   // item minus point before last
  logic signed [DiffBits-1:0] step_dx, step_dy; // item minus last
  logic signed [ProdBits-1:0] seg_sq_x, seg_sq_y, far_sq_x, far_sq_y;
  logic [ProdBits-1:0]        seg_dist, far_dist;
  logic signed [ProdBits-1:0] cross_a, cross_b;
  logic                       is_near, is_farther, is_inline, do_replace;

  // offsets from the last point for the near test
  assign near_dx = DiffBits'(pos_x_i) - DiffBits'(last_x_i);
  assign near_dy = DiffBits'(pos_y_i) - DiffBits'(last_y_i);
  assign near_ax = near_dx[DiffBits-1] ? DiffBits'(-near_dx) : DiffBits'(near_dx);
  assign near_ay = near_dy[DiffBits-1] ? DiffBits'(-near_dy) : DiffBits'(near_dy);
  assign is_near = (near_ax <= DiffBits'(near_limit_i)) &&
                   (near_ay <= DiffBits'(near_limit_i));

  // vectors used by the distance and collinearity tests
  assign seg_dx  = DiffBits'(last_x_i) - DiffBits'(prev_x_i);
  assign seg_dy  = DiffBits'(last_y_i) - DiffBits'(prev_y_i);
  assign far_dx  = DiffBits'(pos_x_i)  - DiffBits'(prev_x_i);
  assign far_dy  = DiffBits'(pos_y_i)  - DiffBits'(prev_y_i);
  assign step_dx = near_dx;
  assign step_dy = near_dy;

  // exact squared distances from the point before last
  assign seg_sq_x = seg_dx * seg_dx;
  assign seg_sq_y = seg_dy * seg_dy;
  assign far_sq_x = far_dx * far_dx;
  assign far_sq_y = far_dy * far_dy;
  assign seg_dist = $unsigned(seg_sq_x) + $unsigned(seg_sq_y);
  assign far_dist = $unsigned(far_sq_x) + $unsigned(far_sq_y);
  assign is_farther = far_dist > seg_dist;

  // collinearity: vertical segment, horizontal segment, else equal cross terms
  assign cross_a = seg_dx * step_dy;
  assign cross_b = seg_dy * step_dx;
  always_comb begin
    if (prev_x_i == last_x_i) begin
      is_inline = (pos_x_i == last_x_i);
    end else if (prev_y_i == last_y_i) begin
      is_inline = (pos_y_i == last_y_i);
    end else begin
      is_inline = (cross_a == cross_b);
    end
  end

  assign do_replace = (count_i > COUNT_W'(2)) && is_farther && is_inline;

  // kind decoder
  always_comb begin
    upd_o    = '0;
    action_o = ACT_DROP;
    unique case (kind_i)
      KIND_BEGIN: begin
        upd_o.clear = 1'b1;
        action_o    = ACT_APPEND;
      end
      KIND_SEED: begin
        upd_o.append = 1'b1;
        action_o     = ACT_APPEND;
      end
      KIND_ADD: begin
        if (count_i == '0) begin
          upd_o.append = 1'b1;
          action_o     = ACT_APPEND;
        end else if (is_near) begin
          action_o = ACT_DROP;
        end else if (do_replace) begin
          upd_o.replace = 1'b1;
          action_o      = ACT_REPLACE;
        end else begin
          upd_o.append = 1'b1;
          action_o     = ACT_APPEND;
        end
      end
      default: begin
        action_o = ACT_DROP;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/stroke_point_decimator.sv @@
// top level of the stroke point decimator
//
// One point beat is taken per clock cycle when the result side keeps up; a
// result leaves through the input register, then the result register. The
// rate is set by the stroke state loop: the last two points and the point
// count are read and rewritten in the same cycle by the decision logic, so
// each point sees the stroke as left by the one before.
// A begin point restarts the stroke, a seed point is always appended, and an
// add point is dropped when near the last point, replaces the last point when
// it continues the same line farther out, and is appended otherwise.
// near_limit should only be written while no points are in flight.
`default_nettype none

module stroke_point_decimator #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  spd_item_if.sink       item_i,
  spd_result_if.source   result_o,
  spd_cfg_if.sink        cfg_i
);
  import spd_pkg::*;

  logic [NEAR_W-1:0] near_limit;

  // input register
  logic                         in_vld_q;
  logic [KIND_W-1:0]            in_kind_q;
  logic signed [COORD_BITS-1:0] in_x_q, in_y_q;

  // stroke state
  logic signed [COORD_BITS-1:0] last_x_q, last_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] last_x_d, last_y_d, prev_x_d, prev_y_d;
  logic [COUNT_W-1:0]           cnt_q, cnt_d, cnt_inc;

  // result register
  logic                         out_vld_q;
  logic [ACTION_W-1:0]          out_action_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [COUNT_W-1:0]           out_slot_q, slot_d;

  spd_upd_t            upd;
  logic [ACTION_W-1:0] action;
  logic                advance, in_take;

  spd_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .near_limit_o (near_limit)
  );

  spd_eval #(
    .CoordBits (COORD_BITS)
  ) u_eval (
    .kind_i       (in_kind_q),
    .pos_x_i      (in_x_q),
    .pos_y_i      (in_y_q),
    .last_x_i     (last_x_q),
    .last_y_i     (last_y_q),
    .prev_x_i     (prev_x_q),
    .prev_y_i     (prev_y_q),
    .count_i      (cnt_q),
    .near_limit_i (near_limit),
    .upd_o        (upd),
    .action_o     (action)
  );

  // handshake between the two registers
  assign advance      = in_vld_q && (!out_vld_q || result_o.ready);
  assign in_take      = item_i.valid && item_i.ready;
  assign item_i.ready = !in_vld_q || advance;

  // next stroke state
  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);
  always_comb begin
    last_x_d = last_x_q;
    last_y_d = last_y_q;
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    cnt_d    = cnt_q;
    if (upd.clear) begin
      last_x_d = in_x_q;
      last_y_d = in_y_q;
      prev_x_d = in_x_q;
      prev_y_d = in_y_q;
      cnt_d    = COUNT_W'(1);
    end else if (upd.append) begin
      prev_x_d = last_x_q;
      prev_y_d = last_y_q;
      last_x_d = in_x_q;
      last_y_d = in_y_q;
      cnt_d    = cnt_inc;
    end else if (upd.replace) begin
      last_x_d = in_x_q;
      last_y_d = in_y_q;
    end
  end

  assign slot_d = (cnt_d == '0) ? '0 : cnt_d - COUNT_W'(1);

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      last_x_q  <= '0;
      last_y_q  <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      cnt_q     <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        last_x_q  <= last_x_d;
        last_y_q  <= last_y_d;
        prev_x_q  <= prev_x_d;
        prev_y_q  <= prev_y_d;
        cnt_q     <= cnt_d;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= item_i.kind;
      in_x_q    <= item_i.pos_x;
      in_y_q    <= item_i.pos_y;
    end
    if (advance) begin
      out_action_q <= action;
      out_x_q      <= in_x_q;
      out_y_q      <= in_y_q;
      out_slot_q   <= slot_d;
    end
  end

  assign result_o.valid      = out_vld_q;
  assign result_o.action     = out_action_q;
  assign result_o.out_x      = out_x_q;
  assign result_o.out_y      = out_y_q;
  assign result_o.slot_index = out_slot_q;

`ifndef SYNTHESIS
  // a begin beat leaves a stroke of one point
  a_begin_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && upd.clear |=> out_vld_q && out_slot_q == '0 && cnt_q == COUNT_W'(1))
    else $error("begin beat did not restart the stroke");

  // replacing the last point needs more than two stored points
  a_replace_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && upd.replace |-> cnt_q > COUNT_W'(2))
    else $error("last point replaced in a short stroke");

  // a dropped point leaves the stroke untouched
  a_drop_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && action == ACT_DROP |=>
      $stable(last_x_q) && $stable(last_y_q) && $stable(prev_x_q) &&
      $stable(prev_y_q) && $stable(cnt_q))
    else $error("dropped point changed the stroke state");

  // at most one update kind per beat
  a_upd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> $onehot0(upd))
    else $error("conflicting stroke updates");
`endif

endmodule

`default_nettype wire

@@ verif/stroke_point_decimator_tb.sv @@
// self-checking testbench of the stroke point decimator: directed and random strokes
`timescale 1ns / 1ps

module stroke_point_decimator_tb;
  import spd_pkg::*;

  localparam int unsigned CW = 16;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PERCENT = 29;

  // one expected result beat
  typedef struct {
    logic [ACTION_W-1:0] action;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic [COUNT_W-1:0] slot_index;
  } outcome_t;

  // stroke state mirror and the queue of outcomes still owed by the block
  class stroke_tracker;
    longint last_x, last_y, prev_x, prev_y;
    int unsigned point_count;
    int unsigned near_limit;
    int unsigned mismatches;
    outcome_t due_outcomes[$];

    function new();
      last_x = 0;
      last_y = 0;
      prev_x = 0;
      prev_y = 0;
      point_count = 0;
      near_limit = NEAR_RESET;
      mismatches = 0;
    endfunction

    function void set_near(int unsigned v);
      near_limit = v;
    endfunction

    function int unsigned pending();
      return due_outcomes.size();
    endfunction

    function longint span(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void push_point(longint ex, longint ey);
      prev_x = last_x;
      prev_y = last_y;
      last_x = ex;
      last_y = ey;
      if (point_count < COUNT_MAX) point_count++;
    endfunction

    // work out the outcome of an accepted point and move the stroke on
    function void take_point(logic [KIND_W-1:0] kind, logic signed [CW-1:0] px,
                             logic signed [CW-1:0] py);
      longint ex, ey, d_last, d_new;
      bit repl;
      outcome_t o;
      ex = px;
      ey = py;
      repl = 1'b0;
      o.action = ACT_DROP;
      case (kind)
        KIND_BEGIN: begin
          last_x = ex;
          prev_x = ex;
          last_y = ey;
          prev_y = ey;
          point_count = 1;
          o.action = ACT_APPEND;
        end
        KIND_SEED: begin
          push_point(ex, ey);
          o.action = ACT_APPEND;
        end
        KIND_ADD: begin
          if (point_count == 0) begin
            push_point(ex, ey);
            o.action = ACT_APPEND;
          end else if (span(ex - last_x) <= near_limit && span(ey - last_y) <= near_limit) begin
            o.action = ACT_DROP;
          end else begin
            // continue the same line farther out: replace instead of append
            if (point_count > 2) begin
              d_last = (last_x - prev_x) * (last_x - prev_x)
                     + (last_y - prev_y) * (last_y - prev_y);
              d_new = (ex - prev_x) * (ex - prev_x) + (ey - prev_y) * (ey - prev_y);
              if (d_last < d_new) begin
                if (prev_x == last_x) repl = (last_x == ex);
                else if (prev_y == last_y) repl = (last_y == ey);
                else repl = ((last_x - prev_x) * (ey - last_y)
                             == (last_y - prev_y) * (ex - last_x));
              end
            end
            if (repl) begin
              last_x = ex;
              last_y = ey;
              o.action = ACT_REPLACE;
            end else begin
              push_point(ex, ey);
              o.action = ACT_APPEND;
            end
          end
        end
        default: o.action = ACT_DROP;
      endcase
      o.out_x = px;
      o.out_y = py;
      o.slot_index = (point_count == 0) ? '0 : COUNT_W'(point_count - 1);
      due_outcomes.push_back(o);
    endfunction

    // compare a result beat with the oldest outcome owed
    function void check_outcome(logic [ACTION_W-1:0] act, logic signed [CW-1:0] rx,
                                logic signed [CW-1:0] ry, logic [COUNT_W-1:0] slot);
      outcome_t o;
      if (due_outcomes.size() == 0) begin
        $error("result beat with no point pending");
        mismatches++;
        return;
      end
      o = due_outcomes.pop_front();
      if (act !== o.action) begin
        $error("action: expected %0d, got %0d", o.action, act);
        mismatches++;
      end
      if (rx !== o.out_x) begin
        $error("out_x: expected %0d, got %0d", o.out_x, rx);
        mismatches++;
      end
      if (ry !== o.out_y) begin
        $error("out_y: expected %0d, got %0d", o.out_y, ry);
        mismatches++;
      end
      if (slot !== o.slot_index) begin
        $error("slot_index: expected %0d, got %0d", o.slot_index, slot);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit no_gaps;
  int unsigned points_sent;
  int unsigned cycles = 0;
  stroke_tracker strokes;

  spd_item_if #(.CoordBits(CW)) item_ch ();
  spd_result_if #(.CoordBits(CW)) result_ch ();
  spd_cfg_if cfg_ch ();

  stroke_point_decimator #(
    .COORD_BITS(CW)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch),
    .result_o(result_ch),
    .cfg_i   (cfg_ch)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // cycle watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL stroke_point_decimator");
      $finish;
    end
  end

  function bit gap_roll();
    return !no_gaps && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  function longint rnd_coord();
    logic signed [CW-1:0] r;
    longint corners[7];
    corners = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    if ($urandom_range(9) == 0) return corners[$urandom_range(6)];
    r = CW'($urandom);
    return r;
  endfunction

  function longint rnd_sym(int unsigned s);
    return longint'($urandom_range(2 * s)) - longint'(s);
  endfunction

  // result side: random back-pressure, every beat checked
  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      result_ch.ready <= !gap_roll();
      @(posedge clk_i);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        strokes.check_outcome(result_ch.action, result_ch.out_x, result_ch.out_y,
                              result_ch.slot_index);
    end
  end

  // one point beat, with random gaps ahead of it
  task automatic drive_item(logic [KIND_W-1:0] kind, longint x, longint y);
    logic signed [CW-1:0] px, py;
    px = x[CW-1:0];
    py = y[CW-1:0];
    while (gap_roll()) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind  <= kind;
    item_ch.pos_x <= px;
    item_ch.pos_y <= py;
    do @(posedge clk_i); while (item_ch.ready !== 1'b1);
    strokes.take_point(kind, px, py);
    points_sent++;
  endtask

  // stop sending and wait until every owed result has come back
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (strokes.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_near(int unsigned v);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.near_limit <= NEAR_W'(v);
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    strokes.set_near(v);
  endtask

  // a stroke of lines with random slope, jitter, turns and stray points
  task automatic draw_stroke(int unsigned n, bit with_begin);
    longint ox, oy, sx, sy, lx, ly, s;
    int unsigned pick;
    int k;
    ox = rnd_coord();
    oy = rnd_coord();
    sx = 0;
    sy = 0;
    k = 0;
    drive_item(with_begin ? KIND_BEGIN : KIND_SEED, ox, oy);
    lx = ox;
    ly = oy;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      // new direction at the start and on every turn
      if (k == 0 && sx == 0 && sy == 0 || pick >= 78 && pick < 88) begin
        ox = lx;
        oy = ly;
        k = 0;
        s = ($urandom_range(3) == 0) ? 1 : $urandom_range(3, 300);
        case ($urandom_range(3))
          0: begin sx = rnd_sym(s); sy = 0; end
          1: begin sx = 0; sy = rnd_sym(s); end
          2: begin sx = rnd_sym(s); sy = ($urandom_range(1) == 0) ? sx : -sx; end
          default: begin sx = rnd_sym(s); sy = rnd_sym(s); end
        endcase
        if (sx == 0 && sy == 0) sx = 1;
      end
      if (pick < 55) begin
        k++;
        lx = ox + k * sx;
        ly = oy + k * sy;
        drive_item((pick < 45) ? KIND_ADD : KIND_SEED, lx, ly);
      end else if (pick < 70) begin
        drive_item(KIND_ADD, lx + rnd_sym(strokes.near_limit + 1),
                   ly + rnd_sym(strokes.near_limit + 1));
      end else if (pick < 78) begin
        // back along the line, halfway towards where it began
        drive_item(KIND_ADD, ox + (k / 2) * sx, oy + (k / 2) * sy);
      end else if (pick < 95 && pick >= 88) begin
        drive_item(KIND_ADD, rnd_coord(), rnd_coord());
      end else if (pick >= 95) begin
        drive_item(($urandom_range(1) == 0) ? KIND_UNUSED : KIND_SEED, rnd_coord(), rnd_coord());
      end
    end
  endtask

  task automatic random_strokes(int unsigned goal);
    int unsigned start;
    start = points_sent;
    while (points_sent - start < goal)
      draw_stroke($urandom_range(3, 40), $urandom_range(9) != 0);
  endtask

  // hand-picked points with the reset near limit
  task automatic directed_points();
    drive_item(KIND_ADD, 5, -7);              // add into an empty stroke
    drive_item(KIND_UNUSED, -32768, 32767);   // unused kind leaves the stroke alone
    drive_item(KIND_BEGIN, 32767, -32768);
    drive_item(KIND_SEED, -32768, 32767);
    drive_item(KIND_ADD, 0, 0);
    // horizontal line
    drive_item(KIND_BEGIN, 0, 0);
    drive_item(KIND_SEED, 10, 0);
    drive_item(KIND_SEED, 20, 0);
    drive_item(KIND_ADD, 30, 0);
    drive_item(KIND_ADD, 31, 1);
    drive_item(KIND_ADD, 40, 0);
    drive_item(KIND_ADD, 40, 5);
    // vertical line, then a step back towards the point before last
    drive_item(KIND_BEGIN, 100, 100);
    drive_item(KIND_SEED, 100, 110);
    drive_item(KIND_SEED, 100, 120);
    drive_item(KIND_ADD, 100, 130);
    drive_item(KIND_ADD, 100, 125);
    // sloped line, then a point off it
    drive_item(KIND_BEGIN, -50, -50);
    drive_item(KIND_SEED, -47, -46);
    drive_item(KIND_SEED, -44, -42);
    drive_item(KIND_ADD, -41, -38);
    drive_item(KIND_ADD, -30, -20);
    // exactly at the near limit, then just outside it
    drive_item(KIND_ADD, -28, -22);
    drive_item(KIND_ADD, -27, -23);
    drive_item(KIND_ADD, 32767, 32767);
  endtask

  initial begin
    strokes = new();
    no_gaps = 1'b0;
    points_sent = 0;
    rst_ni = 1'b0;
    item_ch.valid      <= 1'b0;
    item_ch.kind       <= KIND_BEGIN;
    item_ch.pos_x      <= '0;
    item_ch.pos_y      <= '0;
    result_ch.ready    <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.near_limit  <= NEAR_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_points();

    // sweep the near limit through its extremes and a random middle value, then back to reset
    settle();
    write_near(0);
    random_strokes(400);
    settle();
    write_near(255);
    random_strokes(400);
    settle();
    write_near($urandom_range(1, 254));
    random_strokes(400);
    settle();
    write_near(NEAR_RESET);
    random_strokes(400);

    // one long stroke without gaps on either side
    settle();
    no_gaps = 1'b1;
    drive_item(KIND_BEGIN, rnd_coord(), rnd_coord());
    repeat (200)
      drive_item(($urandom_range(9) == 0) ? KIND_ADD : KIND_SEED, rnd_coord(), rnd_coord());
    repeat (4) draw_stroke(20, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (strokes.mismatches == 0 && strokes.pending() == 0) begin
      $display("PASS stroke_point_decimator");
    end else begin
      $display("FAIL stroke_point_decimator");
    end
    $finish;
  end

endmodule

@@ stroke_point_decimator.f @@
hdl/spd_pkg.sv
hdl/spd_if.sv
hdl/spd_cfg.sv
hdl/spd_eval.sv
hdl/stroke_point_decimator.sv
verif/stroke_point_decimator_tb.sv
